[sv/lsst_pkg.sv]
package lsst_pkg;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_REPORT = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    localparam logic [1:0] REG_SLOTS = 2'd0;
    localparam logic [1:0] REG_RATE  = 2'd1;
    localparam logic [1:0] REG_FLOOR = 2'd2;
    localparam logic [1:0] REG_EMPTY = 2'd3;

    localparam logic [14:0] RATE_RESET  = 15'd1920;
    localparam logic [15:0] FLOOR_RESET = 16'hF100;
    localparam logic [15:0] EMPTY_RESET = 16'h8300;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted transaction
        logic tick_step; // decay the slot at the walk pointer
        logic scan_step; // compare the report against the slot at the pointer
        logic write_hit; // update the matching slot in place
        logic swap_step; // swap the pointer slot with the one above it
        logic shift_step;// move the slot above the pointer down by one
        logic put_new;   // write the new report at the pointer
        logic ptr_up;    // pointer minus one
        logic ptr_next;  // pointer plus one
        logic ptr_last;  // pointer to the last active slot
        logic ptr_zero;  // pointer to slot zero
    } lsst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ptr_at_end;    // pointer is the last active slot (or none)
        logic none_active;
        logic rejected;      // id zero or below floor
        logic hit;           // pointer slot holds the reported id
        logic not_louder;    // report does not exceed the matching slot
        logic beats;         // report is strictly louder than the pointer slot
        logic bubble;        // pointer slot louder than the one above
        logic ptr_zero_now;
        logic ptr_at_ins;    // pointer reached the insert slot
        logic have_ins;      // an insert slot was found during the scan
    } lsst_stat_t;

endpackage

[sv/loudest_source_slot_tracker.sv]
// Loudest-source slot tracker. A transaction is taken when start is high and
// busy is low; it then walks the slots one per cycle. A tick visits each
// active slot once, a report may pass over the slots twice (a scan, then a
// bubble or shift pass) and a read visits none. busy drops in the cycle
// before the result appears, so the next transaction can be taken at the
// edge that opens the previous result's strobe cycle. The single result is
// shown for exactly one cycle on result_valid and the receiver cannot stall
// it. Configuration writes are always ready and are meant to be issued only
// while the block is idle.
module loudest_source_slot_tracker #(
    parameter int MAX_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [15:0]        elapsed,
    input  logic [31:0]        source_id,
    input  logic [31:0]        pos_x,
    input  logic [31:0]        pos_y,
    input  logic [31:0]        pos_z,
    input  logic signed [15:0] level,
    input  logic [2:0]         read_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               result_valid,
    output logic               placed,
    output logic [2:0]         landed_slot,
    output logic               read_ok,
    output logic [31:0]        read_source,
    output logic [31:0]        read_pos_x,
    output logic [31:0]        read_pos_y,
    output logic [31:0]        read_pos_z,
    output logic signed [15:0] read_level
);
    import lsst_pkg::*;

    lsst_cmd_t  cmd;
    lsst_stat_t stat;
    logic       done, placed_set;

    assign cfg_ready = 1'b1;

    lsst_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .mode(mode), .stat(stat),
        .cmd(cmd), .busy(busy), .done(done), .placed_set(placed_set)
    );

    lsst_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .mode(mode),
        .elapsed(elapsed), .source_id(source_id), .pos_x(pos_x), .pos_y(pos_y),
        .pos_z(pos_z), .level(level), .read_index(read_index),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .placed_set(placed_set), .strobe(result_valid),
        .placed(placed), .landed_slot(landed_slot), .read_ok(read_ok),
        .read_source(read_source), .read_pos_x(read_pos_x),
        .read_pos_y(read_pos_y), .read_pos_z(read_pos_z), .read_level(read_level)
    );

endmodule

[sv/lsst_ctrl.sv]
module lsst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          mode,
    input  lsst_pkg::lsst_stat_t stat,
    output lsst_pkg::lsst_cmd_t  cmd,
    output logic                busy,
    output logic                done,
    output logic                placed_set
);
    import lsst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_TICK, S_SCAN, S_BUBBLE, S_SHIFT, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   placed_reg, placed_next;

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign placed_set = placed_reg;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        placed_next = placed_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.ptr_zero = 1'b1;
                    placed_next  = 1'b0;
                    case (mode)
                        MODE_TICK:   state_next = S_TICK;
                        MODE_REPORT: state_next = S_SCAN;
                        default:     state_next = S_FINISH;
                    endcase
                end
            end
            S_TICK:
            begin
                if (stat.none_active)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.tick_step = 1'b1;
                    cmd.ptr_next  = 1'b1;
                    if (stat.ptr_at_end)
                        state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (stat.none_active || stat.rejected)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.hit)
                begin
                    if (stat.not_louder)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.write_hit = 1'b1;
                        placed_next   = 1'b1;
                        state_next    = S_BUBBLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.ptr_at_end)
                    begin
                        if (stat.have_ins || stat.beats)
                        begin
                            cmd.ptr_last = 1'b1;
                            state_next   = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    else
                    begin
                        cmd.ptr_next = 1'b1;
                    end
                end
            end
            S_BUBBLE:
            begin
                if (!stat.ptr_zero_now && stat.bubble)
                begin
                    cmd.swap_step = 1'b1;
                    cmd.ptr_up    = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                if (stat.ptr_at_ins)
                begin
                    cmd.put_new = 1'b1;
                    placed_next = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                    cmd.ptr_up     = 1'b1;
                end
            end
            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            placed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            placed_reg <= placed_next;
        end
    end

endmodule

[sv/lsst_dp.sv]
module lsst_dp #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lsst_pkg::lsst_cmd_t  cmd,
    output lsst_pkg::lsst_stat_t stat,
    input  logic [1:0]          mode,
    input  logic [15:0]         elapsed,
    input  logic [31:0]         source_id,
    input  logic [31:0]         pos_x,
    input  logic [31:0]         pos_y,
    input  logic [31:0]         pos_z,
    input  logic signed [15:0]  level,
    input  logic [2:0]          read_index,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                done,
    input  logic                placed_set,
    output logic                strobe,
    output logic                placed,
    output logic [2:0]          landed_slot,
    output logic                read_ok,
    output logic [31:0]         read_source,
    output logic [31:0]         read_pos_x,
    output logic [31:0]         read_pos_y,
    output logic [31:0]         read_pos_z,
    output logic signed [15:0]  read_level
);
    import lsst_pkg::*;

    localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    logic [31:0]        src_reg [MAX_SLOTS];
    logic [31:0]        px_reg  [MAX_SLOTS];
    logic [31:0]        py_reg  [MAX_SLOTS];
    logic [31:0]        pz_reg  [MAX_SLOTS];
    logic signed [15:0] lvl_reg [MAX_SLOTS];

    logic [CW-1:0]      count_reg;
    logic [14:0]        rate_reg;
    logic signed [15:0] floor_reg, empty_reg;

    logic [1:0]         mode_reg;
    logic [31:0]        id_reg, x_reg, y_reg, z_reg;
    logic signed [15:0] lev_reg;
    logic [2:0]         idx_reg;
    logic [15:0]        dec_reg;
    logic [PW-1:0]      ptr_reg, ins_reg;
    logic               ins_ok_reg;

    logic [PW-1:0]      ptr_m1;
    logic signed [16:0] dec_lvl;
    logic [CW-1:0]      new_cnt, lo_cnt;

    assign ptr_m1  = ptr_reg - 1'b1;
    assign dec_lvl = 17'(lvl_reg[ptr_reg]) - 17'(signed'({1'b0, dec_reg}));

    assign stat.none_active  = (count_reg == '0);
    assign stat.ptr_at_end   = (CW'(ptr_reg) + 1'b1 >= count_reg);
    assign stat.rejected     = (id_reg == '0) || (lev_reg < floor_reg);
    assign stat.hit          = (src_reg[ptr_reg] == id_reg);
    assign stat.not_louder   = (lev_reg <= lvl_reg[ptr_reg]);
    assign stat.beats        = (lev_reg > lvl_reg[ptr_reg]);
    assign stat.bubble       = (lvl_reg[ptr_reg] > lvl_reg[ptr_m1]);
    assign stat.ptr_zero_now = (ptr_reg == '0);
    assign stat.ptr_at_ins   = (ptr_reg == ins_reg);
    assign stat.have_ins     = ins_ok_reg;

    assign new_cnt = (int'(cfg_data[3:0]) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(cfg_data[3:0]);
    assign lo_cnt  = (count_reg < new_cnt) ? count_reg : new_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rate_reg  <= RATE_RESET;
            floor_reg <= FLOOR_RESET;
            empty_reg <= EMPTY_RESET;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                src_reg[i] <= '0;
                px_reg[i]  <= '0;
                py_reg[i]  <= '0;
                pz_reg[i]  <= '0;
                lvl_reg[i] <= EMPTY_RESET;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SLOTS:
                begin
                    count_reg <= new_cnt;
                    for (int i = 0; i < MAX_SLOTS; i++)
                    begin
                        if (CW'(i) >= lo_cnt)
                        begin
                            src_reg[i] <= '0;
                            px_reg[i]  <= '0;
                            py_reg[i]  <= '0;
                            pz_reg[i]  <= '0;
                            lvl_reg[i] <= empty_reg;
                        end
                    end
                end
                REG_RATE:  rate_reg  <= cfg_data[14:0];
                REG_FLOOR: floor_reg <= cfg_data;
                REG_EMPTY: empty_reg <= cfg_data;
                default:   ;
            endcase
        end
        else
        begin
            if (cmd.tick_step)
            begin
                if (dec_lvl < 17'(floor_reg))
                begin
                    lvl_reg[ptr_reg] <= empty_reg;
                    src_reg[ptr_reg] <= '0;
                end
                else
                begin
                    lvl_reg[ptr_reg] <= dec_lvl[15:0];
                end
            end
            if (cmd.write_hit || cmd.put_new)
            begin
                src_reg[ptr_reg] <= id_reg;
                px_reg[ptr_reg]  <= x_reg;
                py_reg[ptr_reg]  <= y_reg;
                pz_reg[ptr_reg]  <= z_reg;
                lvl_reg[ptr_reg] <= lev_reg;
            end
            if (cmd.swap_step)
            begin
                src_reg[ptr_reg] <= src_reg[ptr_m1];
                px_reg[ptr_reg]  <= px_reg[ptr_m1];
                py_reg[ptr_reg]  <= py_reg[ptr_m1];
                pz_reg[ptr_reg]  <= pz_reg[ptr_m1];
                lvl_reg[ptr_reg] <= lvl_reg[ptr_m1];
                src_reg[ptr_m1]  <= src_reg[ptr_reg];
                px_reg[ptr_m1]   <= px_reg[ptr_reg];
                py_reg[ptr_m1]   <= py_reg[ptr_reg];
                pz_reg[ptr_m1]   <= pz_reg[ptr_reg];
                lvl_reg[ptr_m1]  <= lvl_reg[ptr_reg];
            end
            if (cmd.shift_step)
            begin
                src_reg[ptr_reg] <= src_reg[ptr_m1];
                px_reg[ptr_reg]  <= px_reg[ptr_m1];
                py_reg[ptr_reg]  <= py_reg[ptr_m1];
                pz_reg[ptr_reg]  <= pz_reg[ptr_m1];
                lvl_reg[ptr_reg] <= lvl_reg[ptr_m1];
            end
        end
    end

    // Transaction capture, walk pointer and insert point.
    logic [30:0] prod;
    assign prod = 31'(rate_reg) * 31'(elapsed);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            id_reg     <= source_id;
            x_reg      <= pos_x;
            y_reg      <= pos_y;
            z_reg      <= pos_z;
            lev_reg    <= level;
            idx_reg    <= read_index;
            dec_reg    <= prod[30:16] == '0 ? 16'd0 : {1'b0, prod[30:16]};
            ins_ok_reg <= 1'b0;
        end
        else if (cmd.scan_step && stat.beats && !ins_ok_reg)
        begin
            ins_ok_reg <= 1'b1;
            ins_reg    <= ptr_reg;
        end
        if (cmd.ptr_zero)
            ptr_reg <= '0;
        else if (cmd.ptr_last)
            ptr_reg <= PW'(count_reg - 1'b1);
        else if (cmd.ptr_up)
            ptr_reg <= ptr_m1;
        else if (cmd.ptr_next)
            ptr_reg <= ptr_reg + 1'b1;
    end

    // Result register, shown for one cycle.
    logic rd_ok;
    logic [PW-1:0] rd_idx;
    assign rd_idx = PW'(idx_reg);
    assign rd_ok  = (mode_reg == MODE_READ) && (int'(idx_reg) < int'(count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe <= 1'b0;
        else
            strobe <= done;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            placed      <= placed_set;
            landed_slot <= placed_set ? 3'(ptr_reg) : 3'd0;
            read_ok     <= rd_ok;
            read_source <= rd_ok ? src_reg[rd_idx] : '0;
            read_pos_x  <= rd_ok ? px_reg[rd_idx]  : '0;
            read_pos_y  <= rd_ok ? py_reg[rd_idx]  : '0;
            read_pos_z  <= rd_ok ? pz_reg[rd_idx]  : '0;
            read_level  <= rd_ok ? lvl_reg[rd_idx] : '0;
        end
    end

endmodule
